@@ rtl/dgd_pkg.sv @@
`default_nettype none

package dgd_pkg;

  // Field widths of one request and one response.
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned COUNT_W = 22;

  // Day numbers carry one more bit than the count, although the day number of
  // every valid date up to the end of the year range fits in the count field.
  localparam int unsigned NUM_W   = 23;
  localparam int unsigned LEAPS_W = 12;

  localparam int unsigned YEAR_MAX  = 9999;
  localparam int unsigned BASE_YEAR = 1900;
  localparam int unsigned DAYS_PER_YEAR = 365;
  // Leap years from year 1 through 1899.
  localparam int unsigned LEAPS_BASE = 460;

  // Division by 100 of a 14-bit year: multiply by the rounded-up reciprocal.
  localparam int unsigned DIV100_MUL   = 10486;
  localparam int unsigned DIV100_SHIFT = 20;
  localparam int unsigned Q100_W       = 8;
  localparam int unsigned DIV100_PROD_W = 2 * YEAR_W;

  // Division by 7 of a day number: multiply by the rounded-up reciprocal.
  localparam int unsigned DIV7_MUL    = 9586981;
  localparam int unsigned DIV7_MUL_W  = 24;
  localparam int unsigned DIV7_SHIFT  = 26;
  localparam int unsigned DIV7_PROD_W = NUM_W + DIV7_MUL_W;
  localparam int unsigned Q7_W        = DIV7_PROD_W - DIV7_SHIFT;
  localparam int unsigned DAYS_PER_WEEK = 7;

  localparam int unsigned MONTH_FEB = 2;

  // Lane pipeline depth and response queue size.
  localparam int unsigned LANE_LAT    = 5;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QUEUE_AW    = 3;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic              ok;
    logic [WDAY_W-1:0] wday;
    logic [NUM_W-1:0]  num;
    date_t             date;
  } lane_res_t;

  typedef struct packed {
    logic               valid_a;
    logic               valid_b;
    logic [WDAY_W-1:0]  weekday_a;
    logic [WDAY_W-1:0]  weekday_b;
    logic               a_before_b;
    logic [COUNT_W-1:0] day_count;
  } rsp_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = '0;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    n = '0;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dgd_if.sv @@
`default_nettype none

interface dgd_req_if;
  logic                          valid;
  logic                          ready;
  logic [dgd_pkg::YEAR_W-1:0]    year_a;
  logic [dgd_pkg::MONTH_W-1:0]   month_a;
  logic [dgd_pkg::DAY_W-1:0]     day_a;
  logic [dgd_pkg::YEAR_W-1:0]    year_b;
  logic [dgd_pkg::MONTH_W-1:0]   month_b;
  logic [dgd_pkg::DAY_W-1:0]     day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                output ready);
endinterface

interface dgd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_a;
  logic                          valid_b;
  logic [dgd_pkg::WDAY_W-1:0]    weekday_a;
  logic [dgd_pkg::WDAY_W-1:0]    weekday_b;
  logic                          a_before_b;
  logic [dgd_pkg::COUNT_W-1:0]   day_count;

  modport source (output valid, valid_a, valid_b, weekday_a, weekday_b, a_before_b,
                  day_count, input ready);
  modport sink (input valid, valid_a, valid_b, weekday_a, weekday_b, a_before_b,
                day_count, output ready);
endinterface

`default_nettype wire

@@ rtl/gregorian_date_difference.sv @@
// Throughput: one request per cycle while ready is high; two date lanes
// run side by side in a five-stage pipeline and an 8-entry response queue
// absorbs output stalls.
// Ready drops only while 8 requests are accepted but not yet taken out.
// Reset (asynchronous, active low) empties the pipeline and the queue.
`default_nettype none

module gregorian_date_difference (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dgd_req_if.sink    req_i,
  dgd_rsp_if.source  rsp_o
);

  // Each request carries two dates. Lane A handles the first and lane B the
  // second; both compute validity, the day number counted from 1900-01-01 and
  // the weekday. The merge stage then compares the raw fields for ordering,
  // forms the absolute difference of the day numbers and queues the response.

  logic                          req_acc, rsp_acc;
  logic [dgd_pkg::LANE_LAT-1:0]  vld_q, vld_d;
  logic [dgd_pkg::QUEUE_AW:0]    credit_q, credit_d;
  dgd_pkg::date_t                date_a, date_b;
  dgd_pkg::lane_res_t            res_a, res_b;

  assign req_acc = req_i.valid && req_i.ready;
  assign rsp_acc = rsp_o.valid && rsp_o.ready;

  // The credit counter covers every request between acceptance and the
  // moment its response is taken, so the queue can never overflow even
  // though the lane pipeline itself never stalls.
  assign req_i.ready = (credit_q < (dgd_pkg::QUEUE_AW+1)'(dgd_pkg::QUEUE_DEPTH));
  assign credit_d    = credit_q + (dgd_pkg::QUEUE_AW+1)'(req_acc)
                                - (dgd_pkg::QUEUE_AW+1)'(rsp_acc);

  // Valid bits that travel alongside the lane pipeline stages.
  assign vld_d = {vld_q[dgd_pkg::LANE_LAT-2:0], req_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      credit_q <= '0;
    end else begin
      vld_q    <= vld_d;
      credit_q <= credit_d;
    end
  end

  assign date_a = '{year: req_i.year_a, month: req_i.month_a, day: req_i.day_a};
  assign date_b = '{year: req_i.year_b, month: req_i.month_b, day: req_i.day_b};

  dgd_lane u_lane_a (
    .clk_i  (clk_i),
    .date_i (date_a),
    .res_o  (res_a)
  );

  dgd_lane u_lane_b (
    .clk_i  (clk_i),
    .date_i (date_b),
    .res_o  (res_b)
  );

  dgd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld_q[dgd_pkg::LANE_LAT-1]),
    .lane_a_i (res_a),
    .lane_b_i (res_b),
    .rsp_o    (rsp_o)
  );

endmodule

`default_nettype wire

@@ rtl/dgd_lane.sv @@
`default_nettype none

// One date lane: validity, day number since the base date and weekday,
// in a five-stage pipeline that takes a new date every cycle.
module dgd_lane (
  input  wire logic               clk_i,
  input  wire dgd_pkg::date_t     date_i,
  output dgd_pkg::lane_res_t      res_o
);

  // Stage 1: year divided by 100 and the simple range checks.
  logic [dgd_pkg::DIV100_PROD_W-1:0] q100_prod;
  dgd_pkg::date_t                    s1_date_q;
  logic [dgd_pkg::Q100_W-1:0]        s1_q100_q;
  logic [dgd_pkg::YEAR_W-1:0]        s1_yoff_q;
  logic                              s1_yok_q, s1_mok_q, s1_dok_q;

  assign q100_prod = dgd_pkg::DIV100_PROD_W'(date_i.year) *
                     dgd_pkg::DIV100_PROD_W'(dgd_pkg::DIV100_MUL);

  always_ff @(posedge clk_i) begin
    s1_date_q <= date_i;
    s1_q100_q <= q100_prod[dgd_pkg::DIV100_SHIFT +: dgd_pkg::Q100_W];
    s1_yoff_q <= date_i.year - dgd_pkg::YEAR_W'(dgd_pkg::BASE_YEAR);
    s1_yok_q  <= (32'(date_i.year) >= dgd_pkg::BASE_YEAR) &&
                 (32'(date_i.year) <= dgd_pkg::YEAR_MAX);
    s1_mok_q  <= (date_i.month >= 4'd1) && (date_i.month <= 4'd12);
    s1_dok_q  <= (date_i.day != '0);
  end

  // Stage 2: leap year, month length and leap years since the base year.
  logic [dgd_pkg::YEAR_W-1:0]  hund, ym1, leaps_full;
  logic [dgd_pkg::Q100_W-1:0]  qp100;
  logic                        rem0, leap;
  logic [dgd_pkg::NUM_W-1:0]   y365;
  dgd_pkg::date_t              s2_date_q;
  logic                        s2_ok_q, s2_leap_q;
  logic [dgd_pkg::LEAPS_W-1:0] s2_leaps_q;
  logic [dgd_pkg::NUM_W-1:0]   s2_y365_q;

  assign hund  = dgd_pkg::YEAR_W'(s1_q100_q) * dgd_pkg::YEAR_W'(100);
  assign rem0  = (s1_date_q.year == hund);
  assign leap  = rem0 ? (s1_q100_q[1:0] == 2'b00) : (s1_date_q.year[1:0] == 2'b00);
  // Hundreds of year - 1: one less when the year itself is a whole hundred.
  assign qp100 = s1_q100_q - dgd_pkg::Q100_W'(rem0);
  assign ym1   = s1_date_q.year - dgd_pkg::YEAR_W'(1);
  assign leaps_full = dgd_pkg::YEAR_W'(ym1[dgd_pkg::YEAR_W-1:2]) -
                      dgd_pkg::YEAR_W'(qp100) +
                      dgd_pkg::YEAR_W'(qp100[dgd_pkg::Q100_W-1:2]) -
                      dgd_pkg::YEAR_W'(dgd_pkg::LEAPS_BASE);
  assign y365  = dgd_pkg::NUM_W'(s1_yoff_q) * dgd_pkg::NUM_W'(dgd_pkg::DAYS_PER_YEAR);

  always_ff @(posedge clk_i) begin
    s2_date_q  <= s1_date_q;
    s2_ok_q    <= s1_yok_q && s1_mok_q && s1_dok_q &&
                  (s1_date_q.day <= dgd_pkg::month_len(s1_date_q.month, leap));
    s2_leap_q  <= leap;
    s2_leaps_q <= leaps_full[dgd_pkg::LEAPS_W-1:0];
    s2_y365_q  <= y365;
  end

  // Stage 3: day number, forced to zero for an invalid date.
  logic [dgd_pkg::NUM_W-1:0] num;
  logic [dgd_pkg::DAY_W-1:0] dm1;
  dgd_pkg::date_t            s3_date_q;
  logic                      s3_ok_q;
  logic [dgd_pkg::NUM_W-1:0] s3_num_q;

  assign dm1 = s2_date_q.day - dgd_pkg::DAY_W'(1);
  assign num = s2_y365_q + dgd_pkg::NUM_W'(s2_leaps_q) +
               dgd_pkg::NUM_W'(dgd_pkg::days_before(s2_date_q.month)) +
               dgd_pkg::NUM_W'((s2_date_q.month > dgd_pkg::MONTH_W'(dgd_pkg::MONTH_FEB))
                               && s2_leap_q) +
               dgd_pkg::NUM_W'(dm1);

  always_ff @(posedge clk_i) begin
    s3_date_q <= s2_date_q;
    s3_ok_q   <= s2_ok_q;
    s3_num_q  <= s2_ok_q ? num : '0;
  end

  // Stage 4: day number divided by 7.
  logic [dgd_pkg::DIV7_PROD_W-1:0] q7_prod;
  dgd_pkg::date_t                  s4_date_q;
  logic                            s4_ok_q;
  logic [dgd_pkg::NUM_W-1:0]       s4_num_q;
  logic [dgd_pkg::Q7_W-1:0]        s4_q7_q;

  assign q7_prod = dgd_pkg::DIV7_PROD_W'(s3_num_q) *
                   dgd_pkg::DIV7_PROD_W'(dgd_pkg::DIV7_MUL);

  always_ff @(posedge clk_i) begin
    s4_date_q <= s3_date_q;
    s4_ok_q   <= s3_ok_q;
    s4_num_q  <= s3_num_q;
    s4_q7_q   <= q7_prod[dgd_pkg::DIV7_SHIFT +: dgd_pkg::Q7_W];
  end

  // Stage 5: remainder gives the weekday (the base date is a Monday).
  logic [dgd_pkg::NUM_W-1:0] rem7;
  dgd_pkg::lane_res_t        s5_res_q;

  assign rem7 = s4_num_q - dgd_pkg::NUM_W'(s4_q7_q) *
                           dgd_pkg::NUM_W'(dgd_pkg::DAYS_PER_WEEK);

  always_ff @(posedge clk_i) begin
    s5_res_q.date <= s4_date_q;
    s5_res_q.ok   <= s4_ok_q;
    s5_res_q.num  <= s4_num_q;
    s5_res_q.wday <= rem7[dgd_pkg::WDAY_W-1:0];
  end

  assign res_o = s5_res_q;

endmodule

`default_nettype wire

@@ rtl/dgd_merge.sv @@
`default_nettype none

// Combines the two lane results into one response and queues it.
module dgd_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               vld_i,
  input  wire dgd_pkg::lane_res_t lane_a_i,
  input  wire dgd_pkg::lane_res_t lane_b_i,
  dgd_rsp_if.source               rsp_o
);

  logic                      a_first;
  logic [dgd_pkg::NUM_W-1:0] diff;
  dgd_pkg::rsp_t             entry;
  dgd_pkg::rsp_t             mem_q [dgd_pkg::QUEUE_DEPTH];
  dgd_pkg::rsp_t             head;
  logic [dgd_pkg::QUEUE_AW:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic                      pop;

  // Order compares the raw fields, valid or not.
  always_comb begin
    if (lane_a_i.date.year != lane_b_i.date.year) begin
      a_first = lane_a_i.date.year < lane_b_i.date.year;
    end else if (lane_a_i.date.month != lane_b_i.date.month) begin
      a_first = lane_a_i.date.month < lane_b_i.date.month;
    end else begin
      a_first = lane_a_i.date.day < lane_b_i.date.day;
    end
  end

  assign diff = (lane_a_i.num > lane_b_i.num) ? (lane_a_i.num - lane_b_i.num)
                                              : (lane_b_i.num - lane_a_i.num);

  always_comb begin
    entry.valid_a    = lane_a_i.ok;
    entry.valid_b    = lane_b_i.ok;
    entry.weekday_a  = lane_a_i.wday;
    entry.weekday_b  = lane_b_i.wday;
    entry.a_before_b = a_first;
    entry.day_count  = (lane_a_i.ok && lane_b_i.ok) ? diff[dgd_pkg::COUNT_W-1:0] : '0;
  end

  assign pop    = rsp_o.valid && rsp_o.ready;
  assign wptr_d = wptr_q + (dgd_pkg::QUEUE_AW+1)'(vld_i);
  assign rptr_d = rptr_q + (dgd_pkg::QUEUE_AW+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      mem_q[wptr_q[dgd_pkg::QUEUE_AW-1:0]] <= entry;
    end
  end

  assign head = mem_q[rptr_q[dgd_pkg::QUEUE_AW-1:0]];

  assign rsp_o.valid      = (wptr_q != rptr_q);
  assign rsp_o.valid_a    = head.valid_a;
  assign rsp_o.valid_b    = head.valid_b;
  assign rsp_o.weekday_a  = head.weekday_a;
  assign rsp_o.weekday_b  = head.weekday_b;
  assign rsp_o.a_before_b = head.a_before_b;
  assign rsp_o.day_count  = head.day_count;

endmodule

`default_nettype wire

@@ rtl/dgd_checker.sv @@
`default_nettype none

module dgd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic                          valid_a_i,
  input wire logic                          valid_b_i,
  input wire logic [dgd_pkg::WDAY_W-1:0]    weekday_a_i,
  input wire logic [dgd_pkg::WDAY_W-1:0]    weekday_b_i,
  input wire logic                          a_before_b_i,
  input wire logic [dgd_pkg::COUNT_W-1:0]   day_count_i
);

  // An invalid date reports Monday.
  a_wday_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (valid_a_i || weekday_a_i == '0) && (valid_b_i || weekday_b_i == '0))
    else $error("weekday of an invalid date is not zero");

  // No day count unless both dates are valid.
  a_count_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !(valid_a_i && valid_b_i)) |-> day_count_i == '0)
    else $error("day count given for an invalid date pair");

  // Two valid dates with no days between them are the same date.
  a_same_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && valid_a_i && valid_b_i && day_count_i == '0)
      |-> !a_before_b_i && weekday_a_i == weekday_b_i)
    else $error("equal day numbers but dates differ");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response withdrawn while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> $stable(day_count_i) && $stable(weekday_a_i) &&
      $stable(weekday_b_i) && $stable(a_before_b_i) && $stable(valid_a_i) &&
      $stable(valid_b_i))
    else $error("response changed while stalled");

endmodule

bind gregorian_date_difference dgd_checker u_dgd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .valid_a_i    (rsp_o.valid_a),
  .valid_b_i    (rsp_o.valid_b),
  .weekday_a_i  (rsp_o.weekday_a),
  .weekday_b_i  (rsp_o.weekday_b),
  .a_before_b_i (rsp_o.a_before_b),
  .day_count_i  (rsp_o.day_count)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

// Keeps the responses that the accepted requests must produce, in order, and
// checks each response that the block hands out against the oldest of them.
class date_diff_scoreboard;
  dgd_pkg::rsp_t expected_diffs[$];
  int unsigned   mismatches;
  int unsigned   failures;

  static function bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  static function int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Leap years from year 1 through year y.
  static function int unsigned leaps_through(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  static function bit date_ok(dgd_pkg::date_t dt);
    int unsigned y;
    y = dt.year;
    return (y >= dgd_pkg::BASE_YEAR) && (y <= dgd_pkg::YEAR_MAX) &&
           (dt.month >= 1) && (dt.month <= 12) && (dt.day >= 1) &&
           (dt.day <= month_days(dt.month, leap_year(y)));
  endfunction

  // Days since the first of January of the base year; the date must be valid.
  static function int unsigned day_index(dgd_pkg::date_t dt);
    int unsigned y;
    int unsigned n;
    int unsigned k;
    bit          leap;
    y    = dt.year;
    leap = leap_year(y);
    n    = 365 * (y - dgd_pkg::BASE_YEAR) + leaps_through(y - 1) -
           leaps_through(dgd_pkg::BASE_YEAR - 1);
    for (k = 1; k < dt.month; k++) n += month_days(k, leap);
    return n + dt.day - 1;
  endfunction

  function dgd_pkg::rsp_t predict_date_diff(dgd_pkg::date_t a, dgd_pkg::date_t b);
    dgd_pkg::rsp_t r;
    bit [31:0]     num_a;
    bit [31:0]     num_b;
    bit [31:0]     wk;
    bit [31:0]     span;
    r       = '0;
    num_a   = 0;
    num_b   = 0;
    span    = 0;
    r.valid_a = date_ok(a);
    r.valid_b = date_ok(b);
    if (r.valid_a) begin
      num_a       = day_index(a);
      wk          = num_a % 7;
      r.weekday_a = wk[dgd_pkg::WDAY_W-1:0];
    end
    if (r.valid_b) begin
      num_b       = day_index(b);
      wk          = num_b % 7;
      r.weekday_b = wk[dgd_pkg::WDAY_W-1:0];
    end
    r.a_before_b = {a.year, a.month, a.day} < {b.year, b.month, b.day};
    if (r.valid_a && r.valid_b) span = (num_a > num_b) ? num_a - num_b : num_b - num_a;
    r.day_count = span[dgd_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function void note_request(dgd_pkg::date_t a, dgd_pkg::date_t b);
    expected_diffs.push_back(predict_date_diff(a, b));
  endfunction

  function int unsigned outstanding();
    return expected_diffs.size();
  endfunction

  function void check_response(dgd_pkg::rsp_t got);
    dgd_pkg::rsp_t want;
    bit            bad;
    if (expected_diffs.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] response with no request waiting: count %0d", $realtime,
                 got.day_count);
      return;
    end
    want = expected_diffs.pop_front();
    bad  = (got.valid_a !== want.valid_a) || (got.valid_b !== want.valid_b) ||
           (got.weekday_a !== want.weekday_a) || (got.weekday_b !== want.weekday_b) ||
           (got.a_before_b !== want.a_before_b) || (got.day_count !== want.day_count);
    if (bad) begin
      failures++;
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: expected valid %0d/%0d weekday %0d/%0d before %0d count %0d",
                 $realtime, want.valid_a, want.valid_b, want.weekday_a, want.weekday_b,
                 want.a_before_b, want.day_count);
        $display("            actual   valid %0d/%0d weekday %0d/%0d before %0d count %0d",
                 got.valid_a, got.valid_b, got.weekday_a, got.weekday_b,
                 got.a_before_b, got.day_count);
      end
    end
  endfunction

  function void finish_check();
    if (expected_diffs.size() != 0) begin
      failures += expected_diffs.size();
      $display("%0d expected responses never arrived", expected_diffs.size());
    end
  endfunction
endclass

module tb_top;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned CHUNK        = 50;
  localparam int unsigned CHUNKS       = RANDOM_ITEMS / CHUNK;
  // Long enough that the pipeline and the response queue both fill up and the
  // block has to drop ready while requests keep coming.
  localparam int unsigned LONG_STALL   = 60;
  // A correct run ends long before this limit.
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n;

  dgd_req_if req_if ();
  dgd_rsp_if rsp_if ();

  gregorian_date_difference dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  date_diff_scoreboard sb;

  // Idling switches for the two sides. The stimulus process sets them per
  // chunk of requests; the last chunks run with both switched off.
  bit            req_idle_on;
  bit            rsp_idle_on;
  // Set by the stimulus to ask the response side for one long hold-off.
  bit            long_stall_req;
  int unsigned   cycles;
  dgd_pkg::rsp_t seen_rsp;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** gregorian_date_difference: FAILED **");
      $finish;
    end
  end

  // Response monitor. Outputs are sampled at the rising edge, and ready was
  // set by this testbench at the previous falling edge, so the handshake seen
  // here is the one the block sees.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      seen_rsp.valid_a    = rsp_if.valid_a;
      seen_rsp.valid_b    = rsp_if.valid_b;
      seen_rsp.weekday_a  = rsp_if.weekday_a;
      seen_rsp.weekday_b  = rsp_if.weekday_b;
      seen_rsp.a_before_b = rsp_if.a_before_b;
      seen_rsp.day_count  = rsp_if.day_count;
      sb.check_response(seen_rsp);
    end
  end

  // Response side. Ready changes only at the falling edge. A long hold-off,
  // once asked for, is counted down here in whole cycles; otherwise ready
  // drops in random bursts while idling is on.
  initial begin
    int unsigned stall_left;
    int unsigned gap_left;
    stall_left   = 0;
    gap_left     = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end
      if (stall_left != 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else if (gap_left != 0) begin
        rsp_if.ready = 1'b0;
        gap_left--;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready = 1'b0;
        gap_left     = $urandom_range(0, 3);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  function automatic dgd_pkg::date_t mk_date(int unsigned y, int unsigned m,
                                             int unsigned d);
    dgd_pkg::date_t dt;
    dt.year  = y[dgd_pkg::YEAR_W-1:0];
    dt.month = m[dgd_pkg::MONTH_W-1:0];
    dt.day   = d[dgd_pkg::DAY_W-1:0];
    return dt;
  endfunction

  // A valid date, biased toward the ends of the year range, century years,
  // leap years and the first and last day of a month.
  function automatic dgd_pkg::date_t calendar_date();
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned len;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(dgd_pkg::BASE_YEAR, dgd_pkg::BASE_YEAR + 10);
      1:       y = $urandom_range(dgd_pkg::YEAR_MAX - 10, dgd_pkg::YEAR_MAX);
      2:       y = 100 * $urandom_range(dgd_pkg::BASE_YEAR / 100, dgd_pkg::YEAR_MAX / 100);
      3:       y = 4 * $urandom_range(dgd_pkg::BASE_YEAR / 4, dgd_pkg::YEAR_MAX / 4);
      default: y = $urandom_range(dgd_pkg::BASE_YEAR, dgd_pkg::YEAR_MAX);
    endcase
    m   = $urandom_range(1, 12);
    len = sb.month_days(m, sb.leap_year(y));
    case ($urandom_range(0, 3))
      0:       d = len;
      1:       d = 1;
      default: d = $urandom_range(1, len);
    endcase
    return mk_date(y, m, d);
  endfunction

  // A date that just misses being valid in one field, or raw noise.
  function automatic dgd_pkg::date_t broken_date();
    dgd_pkg::date_t dt;
    int unsigned    len;
    dt  = calendar_date();
    len = sb.month_days(dt.month, sb.leap_year(dt.year));
    case ($urandom_range(0, 6))
      0: dt.day   = '0;
      1: dt.day   = dgd_pkg::DAY_W'(len + 1);
      2: dt.month = '0;
      3: dt.month = dgd_pkg::MONTH_W'($urandom_range(13, 15));
      4: dt.year  = dgd_pkg::YEAR_W'($urandom_range(0, dgd_pkg::BASE_YEAR - 1));
      5: dt.year  = dgd_pkg::YEAR_W'($urandom_range(dgd_pkg::YEAR_MAX + 1,
                                                    (1 << dgd_pkg::YEAR_W) - 1));
      default: dt = mk_date($urandom_range(0, (1 << dgd_pkg::YEAR_W) - 1),
                            $urandom_range(0, 15), $urandom_range(0, 31));
    endcase
    return dt;
  endfunction

  // Idle cycles on the request side: valid low, payload scrambled.
  task automatic hold_requests(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      {req_if.year_a, req_if.month_a, req_if.day_a,
       req_if.year_b, req_if.month_b, req_if.day_b} = 46'({$urandom, $urandom});
    end
  endtask

  // Offers one request and waits for the block to take it. Valid stays high
  // into the next request unless an idle burst follows.
  task automatic send_dates(input dgd_pkg::date_t a, input dgd_pkg::date_t b);
    @(negedge clk);
    req_if.valid   = 1'b1;
    req_if.year_a  = a.year;
    req_if.month_a = a.month;
    req_if.day_a   = a.day;
    req_if.year_b  = b.year;
    req_if.month_b = b.month;
    req_if.day_b   = b.day;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    sb.note_request(a, b);
    if (req_idle_on && $urandom_range(0, 3) == 0) hold_requests($urandom_range(1, 4));
  endtask

  // The request side stops until every expected response has come back.
  task automatic drain_responses();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    dgd_pkg::date_t a;
    dgd_pkg::date_t b;
    dgd_pkg::date_t tmp;
    int unsigned    roll;
    int unsigned    chunk;

    sb             = new();
    rst_n          = 1'b0;
    req_idle_on    = 1'b0;
    rsp_idle_on    = 1'b1;
    long_stall_req = 1'b0;
    req_if.valid   = 1'b0;
    req_if.year_a  = '0;
    req_if.month_a = '0;
    req_if.day_a   = '0;
    req_if.year_b  = '0;
    req_if.month_b = '0;
    req_if.day_b   = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests: the ends of the year range in both orders, the three
    // leap rules, month and day edges, every field at zero and at all ones,
    // and invalid dates whose raw fields still decide the order.
    send_dates(mk_date(1900, 1, 1), mk_date(1900, 1, 1));
    send_dates(mk_date(1900, 1, 1), mk_date(dgd_pkg::YEAR_MAX, 12, 31));
    send_dates(mk_date(dgd_pkg::YEAR_MAX, 12, 31), mk_date(1900, 1, 1));
    send_dates(mk_date(2000, 2, 29), mk_date(1900, 2, 29));
    send_dates(mk_date(2004, 2, 29), mk_date(2003, 2, 29));
    send_dates(mk_date(2100, 2, 29), mk_date(2400, 2, 29));
    send_dates(mk_date(2024, 2, 28), mk_date(2024, 3, 1));
    send_dates(mk_date(2020, 5, 0), mk_date(2020, 5, 1));
    send_dates(mk_date(2020, 0, 10), mk_date(2020, 13, 10));
    send_dates(mk_date(2020, 15, 31), mk_date(2020, 12, 31));
    send_dates(mk_date(1899, 12, 31), mk_date(1900, 1, 1));
    send_dates(mk_date(dgd_pkg::YEAR_MAX + 1, 1, 1), mk_date(dgd_pkg::YEAR_MAX, 1, 1));
    send_dates(mk_date(0, 0, 0), mk_date(16383, 15, 31));
    send_dates(mk_date(16383, 15, 31), mk_date(0, 0, 0));
    send_dates(mk_date(2021, 4, 31), mk_date(2021, 4, 30));
    send_dates(mk_date(2021, 4, 30), mk_date(2021, 6, 30));
    send_dates(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
    send_dates(mk_date(1987, 6, 31), mk_date(1987, 6, 31));
    send_dates(mk_date(2023, 1, 31), mk_date(2023, 1, 15));
    send_dates(mk_date(1901, 3, 1), mk_date(1900, 12, 31));
    drain_responses();

    // Random requests in chunks. Most pairs are two valid dates, often in the
    // same year or equal; the rest carry one or two near-misses or raw noise.
    for (chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk >= CHUNKS - 3) begin
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
      end else begin
        req_idle_on = $urandom_range(0, 3) != 0;
        rsp_idle_on = $urandom_range(0, 3) != 0;
      end
      if (chunk == 3) begin
        // Back-to-back requests against a stalled response side.
        req_idle_on    = 1'b0;
        long_stall_req = 1'b1;
      end
      if (chunk == 8) drain_responses();
      repeat (CHUNK) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          a = calendar_date();
          case ($urandom_range(0, 3))
            0: b = a;
            1: begin
              b      = calendar_date();
              b.year = a.year;
            end
            default: b = calendar_date();
          endcase
        end else if (roll < 90) begin
          a = broken_date();
          b = calendar_date();
        end else begin
          a = broken_date();
          b = broken_date();
        end
        if ($urandom_range(0, 1) == 1) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
        send_dates(a, b);
      end
    end

    drain_responses();
    repeat (4 * dgd_pkg::LANE_LAT) @(posedge clk);
    sb.finish_check();
    if (sb.failures == 0) begin
      $display("** gregorian_date_difference: PASSED **");
    end else begin
      $display("** gregorian_date_difference: FAILED **");
    end
    $finish;
  end

endmodule
